>>> rtl/pgrd_pkg.sv
// Shared constants, codes and types for the palettized row dot-product core.
// No dependencies; every other file in rtl/ except pgrd_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pgrd_pkg;

    // Default values for the top-level parameters.
    localparam int CODEBOOK_ENTRIES_DEF = 16;
    localparam int INDICES_PER_WORD_DEF = 8;
    localparam int VALUE_BITS_DEF       = 16;
    localparam int ACC_BITS_DEF         = 56;

    // Fixed field geometry.
    localparam int NIBBLE_BITS     = 4;
    localparam int PACKED_BITS     = 32;
    localparam int MAX_LANES       = 8;
    localparam int FRAC_SHIFT      = 12;
    localparam int ROW_BITS        = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 8;

    // Depth of the result queue behind the pipeline.
    localparam int RES_FIFO_DEPTH  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_WORDS_PER_ROW = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_ROW_COUNT     = 8'd1;

    // Configuration reset values.
    localparam logic [CFG_DATA_BITS-1:0] RESET_WORDS_PER_ROW = 16'd512;
    localparam logic [CFG_DATA_BITS-1:0] RESET_ROW_COUNT     = 16'd4096;

    // Input beat function codes.
    localparam logic FUNC_CB_WRITE = 1'b0;
    localparam logic FUNC_DATA     = 1'b1;

    // Status the merge stage reports to the top level for queue accounting.
    typedef struct packed {
        logic word_done;   // a data word reached the accumulator this cycle
        logic row_done;    // that word also closed the row
    } t_merge_status;

endpackage

`default_nettype wire

>>> rtl/palettized_gemv_row_dot_core.sv
// Top level of the palettized row dot-product core: lanes, merge stage and
// result queue. Depends on pgrd_pkg, pgrd_lane, pgrd_merge and pgrd_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one input beat per cycle, codebook writes and data words alike, and
// a codebook write may be followed in the very next cycle by a word that uses
// it. Each data word is split across INDICES_PER_WORD lanes; every lane keeps
// its own copy of the codebook, looks up its nibble and multiplies by its
// activation, and a two-level adder tree feeds the row accumulator. A row
// result passes the lookup, product, pair, word-sum and finish registers.
// Finished rows wait in an eight-entry result queue, so input keeps
// flowing while results wait; input ready drops only when the data words in
// flight plus queued results reach the queue depth. Configuration writes are
// taken every cycle and are meant to be issued only while the core is idle.
module palettized_gemv_row_dot_core
    import pgrd_pkg::*;
#(
    parameter int CODEBOOK_ENTRIES = CODEBOOK_ENTRIES_DEF,
    parameter int INDICES_PER_WORD = INDICES_PER_WORD_DEF,
    parameter int VALUE_BITS       = VALUE_BITS_DEF,
    parameter int ACC_BITS         = ACC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]    i_cfg_data,

    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire logic                        i_func,
    input  wire logic [NIBBLE_BITS-1:0]      i_cb_index,
    input  wire logic signed [VALUE_BITS-1:0] i_cb_value,
    input  wire logic [PACKED_BITS-1:0]      i_packed_indices,
    input  wire logic signed [VALUE_BITS-1:0] i_act_0,
    input  wire logic signed [VALUE_BITS-1:0] i_act_1,
    input  wire logic signed [VALUE_BITS-1:0] i_act_2,
    input  wire logic signed [VALUE_BITS-1:0] i_act_3,
    input  wire logic signed [VALUE_BITS-1:0] i_act_4,
    input  wire logic signed [VALUE_BITS-1:0] i_act_5,
    input  wire logic signed [VALUE_BITS-1:0] i_act_6,
    input  wire logic signed [VALUE_BITS-1:0] i_act_7,

    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      logic signed [VALUE_BITS-1:0] o_dot_result,
    output      logic [ROW_BITS-1:0]         o_row_number,
    output      logic                        o_last_row,
    output      logic                        o_saturated
);

    localparam int AW     = $clog2(CODEBOOK_ENTRIES);
    localparam int RES_W  = VALUE_BITS + ROW_BITS + 2;
    localparam int PEND_W = $clog2(RES_FIFO_DEPTH + 1);

    logic signed [VALUE_BITS-1:0]   w_act [MAX_LANES];
    logic signed [2*VALUE_BITS-1:0] w_prod [INDICES_PER_WORD];
    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_data_acc;
    logic                           w_cb_wr;

    logic [CFG_DATA_BITS-1:0]       r_words_per_row;
    logic [CFG_DATA_BITS-1:0]       r_row_count;
    logic                           r_a_valid;
    logic                           r_b_valid;
    logic [PEND_W-1:0]              r_pend;

    t_merge_status                  w_status;
    logic                           w_res_valid;
    logic [VALUE_BITS-1:0]          w_res_dot;
    logic [ROW_BITS-1:0]            w_res_row;
    logic                           w_res_last;
    logic                           w_res_sat;
    logic [RES_W-1:0]               w_fifo_out;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = r_pend < PEND_W'(RES_FIFO_DEPTH);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_data_acc  = w_in_acc && (i_func == FUNC_DATA);
    assign w_cb_wr     = w_in_acc && (i_func == FUNC_CB_WRITE)
                         && ({1'b0, i_cb_index} < (NIBBLE_BITS + 1)'(CODEBOOK_ENTRIES));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_per_row <= RESET_WORDS_PER_ROW;
            r_row_count     <= RESET_ROW_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_WORDS_PER_ROW: r_words_per_row <= i_cfg_data;
                CFG_IDX_ROW_COUNT:     r_row_count     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lookup and multiply stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_data_acc;
            r_b_valid <= r_a_valid;
        end
    end

    // Data words in flight plus results waiting; bounds the queue fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PEND_W'(w_data_acc)
                      - PEND_W'(w_status.word_done && !w_status.row_done)
                      - PEND_W'(w_out_acc);
        end
    end

    assign w_act[0] = i_act_0;
    assign w_act[1] = i_act_1;
    assign w_act[2] = i_act_2;
    assign w_act[3] = i_act_3;
    assign w_act[4] = i_act_4;
    assign w_act[5] = i_act_5;
    assign w_act[6] = i_act_6;
    assign w_act[7] = i_act_7;

    // One lane per nibble of the packed word.
    for (genvar j = 0; j < INDICES_PER_WORD; j++) begin : g_lane
        pgrd_lane #(
            .ENTRIES    (CODEBOOK_ENTRIES),
            .VALUE_BITS (VALUE_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (w_cb_wr),
            .i_wr_addr (i_cb_index[AW-1:0]),
            .i_wr_data (i_cb_value),
            .i_rd_en   (w_data_acc),
            .i_index   (i_packed_indices[NIBBLE_BITS*j +: NIBBLE_BITS]),
            .i_act     (w_act[j]),
            .o_prod    (w_prod[j])
        );
    end

    pgrd_merge #(
        .LANES      (INDICES_PER_WORD),
        .VALUE_BITS (VALUE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_prod_valid    (r_b_valid),
        .i_prod          (w_prod),
        .i_words_per_row (r_words_per_row),
        .i_row_count     (r_row_count),
        .o_status        (w_status),
        .o_res_valid     (w_res_valid),
        .o_dot_result    (w_res_dot),
        .o_row_number    (w_res_row),
        .o_last_row      (w_res_last),
        .o_saturated     (w_res_sat)
    );

    pgrd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  ({w_res_dot, w_res_row, w_res_last, w_res_sat}),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (w_fifo_out)
    );

    assign o_dot_result = signed'(w_fifo_out[RES_W-1 -: VALUE_BITS]);
    assign o_row_number = w_fifo_out[ROW_BITS+1 -: ROW_BITS];
    assign o_last_row   = w_fifo_out[1];
    assign o_saturated  = w_fifo_out[0];

    // Credit count stays within the queue depth.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(RES_FIFO_DEPTH))
        else $error("pending count exceeds result queue depth");

    // A result on the output always holds a credit.
    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != '0))
        else $error("result present without a pending credit");

    // A closed row implies a word reached the accumulator.
    a_row_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.row_done |-> w_status.word_done)
        else $error("row closed without a data word");

    // An accepted data word reaches the merge stage through the lookup and multiply valids.
    a_lane_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_data_acc |=> ##1 r_b_valid)
        else $error("lane pipeline lost a data word");

endmodule

`default_nettype wire

>>> rtl/pgrd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the per-lane codebook copies.
`timescale 1ns / 1ps
`default_nettype none

module pgrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/pgrd_lane.sv
// One lane: a private codebook copy, the lookup of one nibble and one multiply.
// Depends on pgrd_pkg and pgrd_ram.
`timescale 1ns / 1ps
`default_nettype none

module pgrd_lane
    import pgrd_pkg::*;
#(
    parameter int ENTRIES    = CODEBOOK_ENTRIES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0]    i_wr_addr,
    input  wire logic [VALUE_BITS-1:0]         i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [NIBBLE_BITS-1:0]        i_index,
    input  wire logic signed [VALUE_BITS-1:0]  i_act,
    output      logic signed [2*VALUE_BITS-1:0] o_prod
);

    localparam int AW = $clog2(ENTRIES);

    logic                          w_in_range;
    logic [VALUE_BITS-1:0]         w_rd_data;
    logic signed [VALUE_BITS-1:0]  w_weight;
    logic                          r_in_range;
    logic signed [VALUE_BITS-1:0]  r_act;
    logic signed [2*VALUE_BITS-1:0] r_prod;

    // Indexes past the codebook size look up zero.
    assign w_in_range = {1'b0, i_index} < (NIBBLE_BITS + 1)'(ENTRIES);

    pgrd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_cb_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_index[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Activation and range flag travel alongside the RAM read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_act      <= i_act;
            r_in_range <= w_in_range;
        end
    end

    assign w_weight = r_in_range ? signed'(w_rd_data) : '0;

    // Full-precision product register.
    always_ff @(posedge i_clk) begin
        r_prod <= w_weight * r_act;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> rtl/pgrd_merge.sv
// Merge stage: adds the lane products, accumulates the row, counts words and
// rows, and shifts and saturates the finished row. Depends on pgrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pgrd_merge
    import pgrd_pkg::*;
#(
    parameter int LANES      = INDICES_PER_WORD_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_prod_valid,
    input  wire logic signed [2*VALUE_BITS-1:0] i_prod [LANES],
    input  wire logic [CFG_DATA_BITS-1:0]       i_words_per_row,
    input  wire logic [CFG_DATA_BITS-1:0]       i_row_count,
    output      t_merge_status                  o_status,
    output      logic                           o_res_valid,
    output      logic [VALUE_BITS-1:0]          o_dot_result,
    output      logic [ROW_BITS-1:0]            o_row_number,
    output      logic                           o_last_row,
    output      logic                           o_saturated
);

    localparam int PB       = 2 * VALUE_BITS;
    localparam int WIDE     = (PB + 3 > ACC_BITS) ? PB + 3 : ACC_BITS;
    localparam int PAIRS    = (LANES + 1) / 2;
    localparam int SHB      = ACC_BITS - FRAC_SHIFT;
    localparam int CMP_BITS = ((SHB > VALUE_BITS) ? SHB : VALUE_BITS) + 1;
    localparam logic signed [CMP_BITS-1:0] SAT_MAX =
        CMP_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [CMP_BITS-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [WIDE-1:0]     w_pair [PAIRS];
    logic signed [WIDE-1:0]     r_pair [PAIRS];
    logic                       r_pair_valid;
    logic signed [WIDE-1:0]     w_wsum;
    logic signed [ACC_BITS-1:0] r_wsum;
    logic                       r_wsum_valid;

    logic signed [ACC_BITS-1:0] r_acc;
    logic [CFG_DATA_BITS-1:0]   r_wc;
    logic [ROW_BITS-1:0]        r_row;
    logic signed [ACC_BITS-1:0] w_acc_new;
    logic [CFG_DATA_BITS-1:0]   w_wc_inc;
    logic                       w_end;
    logic                       w_last;

    logic                       r_fin_valid;
    logic signed [ACC_BITS-1:0] r_fin_acc;
    logic [ROW_BITS-1:0]        r_fin_row;
    logic                       r_fin_last;
    logic signed [ACC_BITS-1:0] w_shifted;
    logic signed [CMP_BITS-1:0] w_x;

    // First adder level: lane products in pairs.
    for (genvar p = 0; p < PAIRS; p++) begin : g_pair
        if (2 * p + 1 < LANES) begin : g_two
            assign w_pair[p] = WIDE'(i_prod[2*p]) + WIDE'(i_prod[2*p+1]);
        end else begin : g_one
            assign w_pair[p] = WIDE'(i_prod[2*p]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= w_pair;
    end

    // Second adder level: sum of the pair results.
    always_comb begin
        w_wsum = '0;
        for (int p = 0; p < PAIRS; p++) begin
            w_wsum = w_wsum + r_pair[p];
        end
    end

    always_ff @(posedge i_clk) begin
        r_wsum <= w_wsum[ACC_BITS-1:0];
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_valid <= 1'b0;
            r_wsum_valid <= 1'b0;
            r_fin_valid  <= 1'b0;
        end else begin
            r_pair_valid <= i_prod_valid;
            r_wsum_valid <= r_pair_valid;
            r_fin_valid  <= r_wsum_valid && w_end;
        end
    end

    // Row accumulation and word / row counting.
    assign w_acc_new = r_acc + r_wsum;
    assign w_wc_inc  = r_wc + 1'b1;
    assign w_end     = w_wc_inc >= i_words_per_row;
    assign w_last    = ({1'b0, r_row} + 1'b1) >= {1'b0, i_row_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_wc  <= '0;
            r_row <= '0;
        end else if (r_wsum_valid) begin
            if (w_end) begin
                r_acc <= '0;
                r_wc  <= '0;
                r_row <= w_last ? '0 : r_row + 1'b1;
            end else begin
                r_acc <= w_acc_new;
                r_wc  <= w_wc_inc;
            end
        end
    end

    // Finished row waits one stage before rounding and clipping.
    always_ff @(posedge i_clk) begin
        if (r_wsum_valid && w_end) begin
            r_fin_acc  <= w_acc_new;
            r_fin_row  <= r_row;
            r_fin_last <= w_last;
        end
    end

    // Arithmetic shift down to Q4.12, then clip to the value range.
    assign w_shifted = r_fin_acc >>> FRAC_SHIFT;
    assign w_x       = w_shifted[CMP_BITS-1:0];

    always_comb begin
        if (w_x > SAT_MAX) begin
            o_dot_result = SAT_MAX[VALUE_BITS-1:0];
            o_saturated  = 1'b1;
        end else if (w_x < SAT_MIN) begin
            o_dot_result = SAT_MIN[VALUE_BITS-1:0];
            o_saturated  = 1'b1;
        end else begin
            o_dot_result = w_x[VALUE_BITS-1:0];
            o_saturated  = 1'b0;
        end
    end

    assign o_res_valid        = r_fin_valid;
    assign o_row_number       = r_fin_row;
    assign o_last_row         = r_fin_last;
    assign o_status.word_done = r_wsum_valid;
    assign o_status.row_done  = r_wsum_valid && w_end;

endmodule

`default_nettype wire

>>> rtl/pgrd_fifo.sv
// Small flop-based queue holding finished row results until they are taken.
// Depends on pgrd_pkg for its default depth.
`timescale 1ns / 1ps
`default_nettype none

module pgrd_fifo
    import pgrd_pkg::*;
#(
    parameter int WIDTH = 34,
    parameter int DEPTH = RES_FIFO_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output      logic             o_valid,
    output      logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

    // The upstream credit scheme must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count out of range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("result queue count did not follow a push");

endmodule

`default_nettype wire

>>> test/tb_palettized_gemv_row_dot_core.sv
// Self-checking bench for the palettized row dot-product core: a directed table, then
// random phases under several row shapes, checked against an in-bench row model or typed-in rows.
// Depends on pgrd_pkg and palettized_gemv_row_dot_core.
`timescale 1ns / 1ps

module tb_palettized_gemv_row_dot_core;
    import pgrd_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int AB          = ACC_BITS_DEF;
    localparam int SETTLE      = 10;    // lets the pipe empty after the last result
    localparam int QUIET_LIMIT = 500;   // cycles with no beat moving on any channel
    localparam int PHASES      = 9;
    localparam int DIR_ROWS    = 19;

    localparam logic signed [AB-1:0] DOT_MAX = (1 <<< (VB - 1)) - 1;
    localparam logic signed [AB-1:0] DOT_MIN = -(1 <<< (VB - 1));

    typedef struct packed {
        logic signed [VB-1:0]   dot;
        logic [ROW_BITS-1:0]    row;
        logic                   last;
        logic                   sat;
    } t_row_result;

    // One input beat; chk marks a directed row whose result is typed in by hand.
    typedef struct packed {
        logic                             func;
        logic [NIBBLE_BITS-1:0]           cb_idx;
        logic [VB-1:0]                    cb_val;
        logic [PACKED_BITS-1:0]           nibbles;
        logic [MAX_LANES-1:0][VB-1:0]     acts;
        logic                             chk;
        t_row_result                      want;
    } t_beat;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_func = 1'b0;
    logic [NIBBLE_BITS-1:0]       i_cb_index = '0;
    logic signed [VB-1:0]         i_cb_value = '0;
    logic [PACKED_BITS-1:0]       i_packed_indices = '0;
    logic signed [VB-1:0]         i_act_0 = '0;
    logic signed [VB-1:0]         i_act_1 = '0;
    logic signed [VB-1:0]         i_act_2 = '0;
    logic signed [VB-1:0]         i_act_3 = '0;
    logic signed [VB-1:0]         i_act_4 = '0;
    logic signed [VB-1:0]         i_act_5 = '0;
    logic signed [VB-1:0]         i_act_6 = '0;
    logic signed [VB-1:0]         i_act_7 = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [VB-1:0]         o_dot_result;
    logic [ROW_BITS-1:0]          o_row_number;
    logic                         o_last_row;
    logic                         o_saturated;

    // Mirror of the core state and its two shape registers.
    logic signed [VB-1:0]         cb_mirror [CODEBOOK_ENTRIES_DEF];
    logic signed [AB-1:0]         acc_mirror = '0;
    logic [ROW_BITS-1:0]          word_mirror = '0;
    logic [ROW_BITS-1:0]          row_mirror = '0;
    logic [CFG_DATA_BITS-1:0]     wpr_mirror = RESET_WORDS_PER_ROW;
    logic [CFG_DATA_BITS-1:0]     rc_mirror = RESET_ROW_COUNT;

    t_row_result                  pending_rows [$];
    int                           cb_known [$];
    bit [CODEBOOK_ENTRIES_DEF-1:0] cb_seen = '0;
    t_beat                        dir_tab [DIR_ROWS];
    bit                           idle_en = 1'b1;
    int                           out_hold = 0;
    int                           quiet_cycles = 0;
    int                           errors = 0;

    // Row shapes per random phase; a negative entry is drawn at random.
    int plan_wpr [PHASES] = '{0, 3, 1, 8, 2, -1, -1, 65535, 4};
    int plan_rc  [PHASES] = '{0, 5, 65535, 2, 1, -1, -1, 65535, 3};
    int plan_len [PHASES] = '{120, 200, 200, 200, 160, 200, 200, 60, 130};

    palettized_gemv_row_dot_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_cb_index       (i_cb_index),
        .i_cb_value       (i_cb_value),
        .i_packed_indices (i_packed_indices),
        .i_act_0          (i_act_0),
        .i_act_1          (i_act_1),
        .i_act_2          (i_act_2),
        .i_act_3          (i_act_3),
        .i_act_4          (i_act_4),
        .i_act_5          (i_act_5),
        .i_act_6          (i_act_6),
        .i_act_7          (i_act_7),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_dot_result     (o_dot_result),
        .o_row_number     (o_row_number),
        .o_last_row       (o_last_row),
        .o_saturated      (o_saturated)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Folds one data word into the mirrored accumulator and closes the row when due.
    task automatic fold_word(input t_beat b, output bit closed, output t_row_result r);
        logic signed [2*VB-1:0] prod;
        logic signed [AB-1:0]   scaled;
        closed = 1'b0;
        r = '0;
        for (int j = 0; j < MAX_LANES; j++) begin
            prod = cb_mirror[b.nibbles[NIBBLE_BITS*j +: NIBBLE_BITS]] * $signed(b.acts[j]);
            acc_mirror = acc_mirror + prod;
        end
        word_mirror = word_mirror + 1'b1;
        if (word_mirror >= wpr_mirror) begin
            closed = 1'b1;
            scaled = acc_mirror >>> FRAC_SHIFT;
            if (scaled > DOT_MAX) begin
                r.dot = DOT_MAX[VB-1:0];
                r.sat = 1'b1;
            end else if (scaled < DOT_MIN) begin
                r.dot = DOT_MIN[VB-1:0];
                r.sat = 1'b1;
            end else begin
                r.dot = scaled[VB-1:0];
            end
            r.row = row_mirror;
            r.last = (int'(row_mirror) + 1) >= int'(rc_mirror);
            row_mirror = r.last ? '0 : row_mirror + 1'b1;
            acc_mirror = '0;
            word_mirror = '0;
        end
    endtask

    // Q4.12 values weighted toward the extremes and toward small magnitudes.
    function automatic logic [VB-1:0] rand_q412();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2, 3: return VB'(int'($urandom_range(0, 1023)) - 512);
            default: return VB'($urandom);
        endcase
    endfunction

    // Random beat; data words only reference codebook entries already written.
    task automatic make_beat(output t_beat b);
        b = '0;
        b.func = ($urandom_range(0, 4) == 0) ? FUNC_CB_WRITE : FUNC_DATA;
        b.cb_idx = NIBBLE_BITS'($urandom);
        b.cb_val = rand_q412();
        for (int j = 0; j < MAX_LANES; j++) begin
            b.nibbles[NIBBLE_BITS*j +: NIBBLE_BITS] =
                NIBBLE_BITS'(cb_known[$urandom_range(0, cb_known.size() - 1)]);
            b.acts[j] = rand_q412();
        end
    endtask

    // Presents one beat from a falling edge, waits for the accept, then updates the mirror.
    task automatic drive_beat(input t_beat b);
        bit          closed;
        t_row_result got;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= b.func;
        i_cb_index       <= b.cb_idx;
        i_cb_value       <= b.cb_val;
        i_packed_indices <= b.nibbles;
        i_act_0          <= b.acts[0];
        i_act_1          <= b.acts[1];
        i_act_2          <= b.acts[2];
        i_act_3          <= b.acts[3];
        i_act_4          <= b.acts[4];
        i_act_5          <= b.acts[5];
        i_act_6          <= b.acts[6];
        i_act_7          <= b.acts[7];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (b.func == FUNC_CB_WRITE) begin
            cb_mirror[b.cb_idx] = b.cb_val;
            if (!cb_seen[b.cb_idx]) begin
                cb_seen[b.cb_idx] = 1'b1;
                cb_known.push_back(int'(b.cb_idx));
            end
        end else begin
            fold_word(b, closed, got);
            if (closed) pending_rows.push_back(b.chk ? b.want : got);
        end
        @(negedge i_clk);
    endtask

    // Drops input valid and waits until every row has come back and the pipe is empty.
    task automatic park_and_drain();
        i_in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Writes both shape registers back to back; valid stays high across the two beats.
    task automatic program_shape(input logic [CFG_DATA_BITS-1:0] wpr,
                                 input logic [CFG_DATA_BITS-1:0] rc);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_WORDS_PER_ROW;
        i_cfg_data  <= wpr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        wpr_mirror = wpr;
        @(negedge i_clk);
        i_cfg_index <= CFG_IDX_ROW_COUNT;
        i_cfg_data  <= rc;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        rc_mirror = rc;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic match_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Result checker: every accepted beat is matched against the oldest expected row.
    always @(posedge i_clk) begin : check_rows
        t_row_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rows.size() == 0) begin
                $display("%0t ns: unexpected row beat, expected none, actual dot %0d row %0d",
                         $time, o_dot_result, o_row_number);
                errors++;
            end else begin
                want = pending_rows.pop_front();
                match_field("dot_result", longint'(want.dot), longint'(o_dot_result));
                match_field("row_number", longint'(want.row), longint'(o_row_number));
                match_field("last_row", longint'(want.last), longint'(o_last_row));
                match_field("saturated", longint'(want.sat), longint'(o_saturated));
            end
        end
    end

    // Result side backpressure in short bursts.
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_ready <= 1'b0;
            out_hold <= out_hold - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            out_hold <= $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: the run is hung when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_beat b;
        int    wpr;
        int    rc;

        // Directed rows, run with one word per row and three rows per matrix.
        // Codebook loads with the value extremes, unity, the smallest step and minus one.
        dir_tab[0]  = '{FUNC_CB_WRITE, 4'd0, 16'h7FFF, 32'h0, '0, 1'b0, '0};
        dir_tab[1]  = '{FUNC_CB_WRITE, 4'd1, 16'h8000, 32'h0, '0, 1'b0, '0};
        dir_tab[2]  = '{FUNC_CB_WRITE, 4'd2, 16'h1000, 32'h0, '0, 1'b0, '0};
        dir_tab[3]  = '{FUNC_CB_WRITE, 4'd3, 16'h0001, 32'h0, '0, 1'b0, '0};
        dir_tab[4]  = '{FUNC_CB_WRITE, 4'd15, 16'hF000, 32'h0, '0, 1'b0, '0};
        // Most negative squared in every lane: clips high.
        dir_tab[5]  = '{FUNC_DATA, 4'd0, 16'h0, 32'h11111111, {8{16'h8000}}, 1'b1,
                        '{16'sh7FFF, 16'd0, 1'b0, 1'b1}};
        // Most negative times most positive: clips low.
        dir_tab[6]  = '{FUNC_DATA, 4'd0, 16'h0, 32'h11111111, {8{16'h7FFF}}, 1'b1,
                        '{16'sh8000, 16'd1, 1'b0, 1'b0 | 1'b1}};
        // Unity times one eighth in all lanes gives exactly one; last row of three.
        dir_tab[7]  = '{FUNC_DATA, 4'd0, 16'h0, 32'h22222222, {8{16'h0200}}, 1'b1,
                        '{16'sh1000, 16'd2, 1'b1, 1'b0}};
        // Tiny negative sum rounds toward minus infinity; row number has wrapped.
        dir_tab[8]  = '{FUNC_DATA, 4'd0, 16'h0, 32'h33333333, {8{16'hFFFF}}, 1'b1,
                        '{16'shFFFF, 16'd0, 1'b0, 1'b0}};
        dir_tab[9]  = '{FUNC_DATA, 4'd0, 16'h0, 32'h00000000, {8{16'h7FFF}}, 1'b1,
                        '{16'sh7FFF, 16'd1, 1'b0, 1'b1}};
        dir_tab[10] = '{FUNC_DATA, 4'd0, 16'h0, 32'hFFFFFFFF, {8{16'h0001}}, 1'b1,
                        '{16'shFFF8, 16'd2, 1'b1, 1'b0}};
        // Codebook rewrite with junk on the data fields, used on the very next beat.
        dir_tab[11] = '{FUNC_CB_WRITE, 4'd15, 16'h0800, 32'hFFFFFFFF, {8{16'h7FFF}}, 1'b0,
                        '0};
        dir_tab[12] = '{FUNC_DATA, 4'd0, 16'h0, 32'hFFFFFFFF, {8{16'h1000}}, 1'b1,
                        '{16'sh4000, 16'd0, 1'b0, 1'b0}};
        // Largest positive result that fits, then one step past it.
        dir_tab[13] = '{FUNC_DATA, 4'd0, 16'h0, 32'h22222222, {16'h0FFF, {7{16'h1000}}},
                        1'b1, '{16'sh7FFF, 16'd1, 1'b0, 1'b0}};
        dir_tab[14] = '{FUNC_DATA, 4'd0, 16'h0, 32'h22222222, {8{16'h1000}}, 1'b1,
                        '{16'sh7FFF, 16'd2, 1'b1, 1'b1}};
        // Most negative result that fits, then one step past it.
        dir_tab[15] = '{FUNC_DATA, 4'd0, 16'h0, 32'h22222222, {8{16'hF000}}, 1'b1,
                        '{16'sh8000, 16'd0, 1'b0, 1'b0}};
        dir_tab[16] = '{FUNC_DATA, 4'd0, 16'h0, 32'h22222222, {16'hEFFF, {7{16'hF000}}},
                        1'b1, '{16'sh8000, 16'd1, 1'b0, 1'b1}};
        // Mixed lanes, checked by the row model.
        dir_tab[17] = '{FUNC_DATA, 4'd9, 16'h5A5A, 32'hF3210F32,
                        {16'h1234, 16'hEDCB, 16'h7FFF, 16'h8000,
                         16'h0001, 16'hFFFF, 16'h0ABC, 16'hF543}, 1'b0, '0};
        dir_tab[18] = '{FUNC_DATA, 4'd6, 16'hA5A5, 32'h0123F321,
                        {16'h4000, 16'hC000, 16'h0010, 16'hFFF0,
                         16'h2222, 16'hDDDD, 16'h0100, 16'hFF00}, 1'b0, '0};

        // Synchronous reset, released on a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        program_shape(16'd1, 16'd3);
        foreach (dir_tab[k]) drive_beat(dir_tab[k]);

        // Random phases; the shape changes only once the core has gone idle,
        // often with a row left part way, and the final phase runs without idling.
        for (int p = 0; p < PHASES; p++) begin
            park_and_drain();
            wpr = (plan_wpr[p] < 0) ? $urandom_range(1, 12) : plan_wpr[p];
            rc  = (plan_rc[p] < 0) ? $urandom_range(0, 6) : plan_rc[p];
            program_shape(CFG_DATA_BITS'(wpr), CFG_DATA_BITS'(rc));
            idle_en = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (plan_len[p]) begin
                make_beat(b);
                drive_beat(b);
            end
        end

        park_and_drain();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pgrd_pkg.sv
rtl/pgrd_ram.sv
rtl/pgrd_lane.sv
rtl/pgrd_merge.sv
rtl/pgrd_fifo.sv
rtl/palettized_gemv_row_dot_core.sv
test/tb_palettized_gemv_row_dot_core.sv
